// ----- rtl/ilc_pkg.sv -----
// ilc_pkg: shared types for the indexed list with capacity
// command and status codes, and the per-cell update selector
// no dependencies
package ilc_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_LOW  = 2'd2,
    CELL_FROM_HIGH = 2'd3
  } cell_op_e;

endpackage

// ----- rtl/ilc_cell.sv -----
// ilc_cell: one list slot, holding a single word
// takes a new word, the word of its lower or upper neighbour, or holds
// depends on ilc_pkg
module ilc_cell
  import ilc_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [WORD_WIDTH-1:0] load_word_i,
  input  logic [WORD_WIDTH-1:0] low_word_i,
  input  logic [WORD_WIDTH-1:0] high_word_i,
  output logic [WORD_WIDTH-1:0] word_o
);

  logic [WORD_WIDTH-1:0] word_q, word_d;

  always_comb begin
    case (op_i)
      CELL_LOAD:      word_d = load_word_i;
      CELL_FROM_LOW:  word_d = low_word_i;
      CELL_FROM_HIGH: word_d = high_word_i;
      default:        word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- rtl/indexed_list_with_capacity.sv -----
// indexed_list_with_capacity: ordered word list in a row of shifting cells,
// with size and a doubling/halving logical capacity
// depends on ilc_pkg and ilc_cell
//
//   channel | direction | fields                                        | handshake
//   in      | to block  | command_i, index_i, value_i                   | in_valid_i / in_ready_o
//   out     | from block| read_value_o, size_now_o, capacity_now_o,     | out_valid_o / out_ready_i
//           |           | status_o, appended_o                          |
//
// for every command the cells shift or load at the edge that ends the
// transfer, and the result lands in the output register at the same edge.
// the depth of the read mux over the cell row sets the cycle time.
// reset clears size to zero and capacity to one; cell contents are not reset.
// a waiting result stalls input only while out_ready_i is low.
module indexed_list_with_capacity
  import ilc_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [CW-1:0]         index_i,
  input  logic [WORD_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WORD_WIDTH-1:0] read_value_o,
  output logic [CW-1:0]         size_now_o,
  output logic [CW-1:0]         capacity_now_o,
  output logic [1:0]            status_o,
  output logic                  appended_o
);

  localparam logic [CW:0] DEPTH_EXT = (CW + 1)'(DEPTH);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cap_q, cap_d;
  logic          out_valid_q;
  logic [WORD_WIDTH-1:0] read_value_q, read_value_d;
  status_e       status_q, status_d;
  logic          appended_q, appended_d;

  logic [WORD_WIDTH-1:0] words [DEPTH];
  cell_op_e              ops   [DEPTH];

  logic      in_xfer;
  cmd_e      cmd;
  logic      do_place, do_remove, do_replace;
  logic [WORD_WIDTH-1:0] sel_word;
  logic [CW:0]   cap_grow;
  logic [CW-1:0] cnt_dec, cap_h1, cap_h2;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);

  // row of cells, each fed by its neighbours
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] low_w, high_w;
    if (g == 0) begin : g_first
      assign low_w = words[g];
    end else begin : g_low
      assign low_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign high_w = words[g];
    end else begin : g_high
      assign high_w = words[g+1];
    end
    ilc_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (ops[g]),
      .load_word_i(value_i),
      .low_word_i (low_w),
      .high_word_i(high_w),
      .word_o     (words[g])
    );
  end

  assign sel_word = words[index_i[AW-1:0]];

  // command decode and status
  always_comb begin
    status_d     = ST_OK;
    read_value_d = '0;
    appended_d   = 1'b0;
    do_place     = 1'b0;
    do_remove    = 1'b0;
    do_replace   = 1'b0;
    unique case (cmd)
      CMD_INSERT: begin
        if (index_i > cnt_q) status_d = ST_RANGE;
        else if ((CW + 1)'(cnt_q) >= DEPTH_EXT) status_d = ST_FULL;
        else do_place = 1'b1;
      end
      CMD_REMOVE: begin
        if (cnt_q == '0) status_d = ST_EMPTY;
        else if (index_i >= cnt_q) status_d = ST_RANGE;
        else begin
          do_remove    = 1'b1;
          read_value_d = sel_word;
        end
      end
      CMD_GET: begin
        if (cnt_q == '0) status_d = ST_EMPTY;
        else if (index_i >= cnt_q) status_d = ST_RANGE;
        else read_value_d = sel_word;
      end
      CMD_SET: begin
        if (index_i > cnt_q) status_d = ST_RANGE;
        else if (index_i == cnt_q) begin
          if ((CW + 1)'(cnt_q) >= DEPTH_EXT) status_d = ST_FULL;
          else begin
            do_place   = 1'b1;
            appended_d = 1'b1;
          end
        end else begin
          do_replace   = 1'b1;
          read_value_d = sel_word;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // capacity: grow when full on a place, halve up to twice after a remove
  assign cap_grow = (cap_q == cnt_q) ? {cap_q, 1'b0} : (CW + 1)'(cap_q);
  assign cnt_dec  = cnt_q - CW'(1);
  assign cap_h1   = (({2'b00, cnt_dec} << 2) < (CW + 2)'(cap_q) && cap_q > CW'(1))
                    ? (cap_q >> 1) : cap_q;
  assign cap_h2   = (({2'b00, cnt_dec} << 2) < (CW + 2)'(cap_h1) && cap_h1 > CW'(1))
                    ? (cap_h1 >> 1) : cap_h1;

  always_comb begin
    cnt_d = cnt_q;
    cap_d = cap_q;
    if (in_xfer) begin
      if (do_place) begin
        cnt_d = cnt_q + CW'(1);
        cap_d = (cap_grow > DEPTH_EXT) ? CW'(DEPTH) : cap_grow[CW-1:0];
      end else if (do_remove) begin
        cnt_d = cnt_dec;
        cap_d = cap_h2;
      end
    end
  end

  // per-cell update selects
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = CELL_HOLD;
      if (in_xfer) begin
        if (do_place) begin
          if (CW'(i) == index_i) ops[i] = CELL_LOAD;
          else if (CW'(i) > index_i && CW'(i) <= cnt_q) ops[i] = CELL_FROM_LOW;
        end else if (do_remove) begin
          if (CW'(i) >= index_i && (CW + 1)'(i) + (CW + 1)'(1) < (CW + 1)'(cnt_q)) begin
            ops[i] = CELL_FROM_HIGH;
          end
        end else if (do_replace) begin
          if (CW'(i) == index_i) ops[i] = CELL_LOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cap_q <= cap_d;
      if (in_xfer) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
      appended_q   <= appended_d;
    end
  end

  logic [CW-1:0] size_res_q, cap_res_q;
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      size_res_q <= cnt_d;
      cap_res_q  <= cap_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = read_value_q;
  assign size_now_o     = size_res_q;
  assign capacity_now_o = cap_res_q;
  assign status_o       = status_q;
  assign appended_o     = appended_q;

endmodule
